### sv/imc_pkg.sv
// Package for the IMU measurement compensation block: item types, coefficient
// bundle type, widths, pipeline depths and register indexes. No dependencies.
package imc_pkg;

    localparam int MEAS_W    = 32;
    localparam int DT_W      = 24;
    localparam int CFG_W     = 48;
    localparam int CFG_NUM   = 8;
    localparam int CFG_IDX_W = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACC_BIAS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACC_SCL  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACC_MUP  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACC_MLO  = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GYR_BIAS = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GYR_SCL  = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GYR_MUP  = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_GYR_MLO  = 8'd7;
    localparam int REGS_PER_SENSOR = 4;

    localparam int VW    = 34;   // bias-corrected measurement
    localparam int PW    = 17;   // misalignment entry, Q1.15 with room for 1.0
    localparam int AW    = 35;   // adjugate entry
    localparam int CW    = 66;   // adjugate times scale product
    localparam int DETW  = 54;
    localparam int DMAGW = 48;
    localparam int A3W   = 48;
    localparam int D2W   = 97;   // twice the denominator
    localparam int NW    = 102;  // numerator sum
    localparam int RW    = 134;  // divider remainder
    localparam int QW    = 33;   // quotient bits kept

    localparam int LANE_ST  = 38;            // stages inside a lane
    localparam int NS       = LANE_ST + 2;   // whole item pipeline
    localparam int SETTLE   = 7;
    localparam int SETTLE_W = 3;

    typedef struct packed {
        logic signed [MEAS_W-1:0] dvel_x;
        logic signed [MEAS_W-1:0] dvel_y;
        logic signed [MEAS_W-1:0] dvel_z;
        logic signed [MEAS_W-1:0] dang_x;
        logic signed [MEAS_W-1:0] dang_y;
        logic signed [MEAS_W-1:0] dang_z;
        logic [DT_W-1:0]          interval;
    } t_in_item;

    typedef struct packed {
        logic signed [MEAS_W-1:0] comp_dvel_x;
        logic signed [MEAS_W-1:0] comp_dvel_y;
        logic signed [MEAS_W-1:0] comp_dvel_z;
        logic signed [MEAS_W-1:0] comp_dang_x;
        logic signed [MEAS_W-1:0] comp_dang_y;
        logic signed [MEAS_W-1:0] comp_dang_z;
        logic                     accel_singular;
        logic                     gyro_singular;
    } t_out_item;

    typedef struct packed {
        logic [2:0][2:0][CW-1:0] c;
        logic [D2W-1:0]          den2;
        logic                    det_neg;
        logic                    singular;
    } t_coef;

endpackage

### sv/imc_coef.sv
// Per-sensor coefficient pipeline: adjugate, determinant and scale products
// derived from the scale and misalignment registers. Depends on imc_pkg.
module imc_coef (
    input  logic                 i_clk,
    input  logic [imc_pkg::CFG_W-1:0] i_scale,
    input  logic [imc_pkg::CFG_W-1:0] i_mis_up,
    input  logic [imc_pkg::CFG_W-1:0] i_mis_lo,
    output imc_pkg::t_coef       o_coef
);
    import imc_pkg::*;

    logic signed [PW-1:0] w_p [3][3];
    logic signed [AW-1:0] w_adj [3][3];
    logic [15:0]          w_a [3];

    logic signed [PW-1:0] r_p0 [3];
    logic signed [AW-1:0] r_adj [3][3];
    logic [15:0]          r_a [3];

    logic signed [DETW-1:0] r_det;
    logic signed [AW-1:0]   r_adjb [3][3];
    logic [31:0]            r_oth [3];
    logic [15:0]            r_a0;
    logic                   r_a_zero;

    logic [2:0][2:0][CW-1:0] r_c;
    logic [2:0][2:0][CW-1:0] r_c2;
    logic [A3W-1:0]          r_a3;
    logic [DMAGW-1:0]        r_dmag;
    logic                    r_dneg, r_sing, r_dneg2, r_sing2;
    logic [71:0]             r_pl, r_ph;

    logic signed [DETW-1:0] n_det;
    logic [DETW-1:0]        n_dabs;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_a[i]    = {~i_scale[16*i+15], i_scale[16*i +: 15]};
            w_p[i][i] = 17'sd32768;
        end
        w_p[0][1] = PW'($signed(i_mis_up[15:0]));
        w_p[0][2] = PW'($signed(i_mis_up[31:16]));
        w_p[1][0] = PW'($signed(i_mis_up[47:32]));
        w_p[1][2] = PW'($signed(i_mis_lo[15:0]));
        w_p[2][0] = PW'($signed(i_mis_lo[31:16]));
        w_p[2][1] = PW'($signed(i_mis_lo[47:32]));
        w_adj[0][0] = AW'(w_p[1][1] * w_p[2][2]) - AW'(w_p[1][2] * w_p[2][1]);
        w_adj[0][1] = AW'(w_p[0][2] * w_p[2][1]) - AW'(w_p[0][1] * w_p[2][2]);
        w_adj[0][2] = AW'(w_p[0][1] * w_p[1][2]) - AW'(w_p[0][2] * w_p[1][1]);
        w_adj[1][0] = AW'(w_p[1][2] * w_p[2][0]) - AW'(w_p[1][0] * w_p[2][2]);
        w_adj[1][1] = AW'(w_p[0][0] * w_p[2][2]) - AW'(w_p[0][2] * w_p[2][0]);
        w_adj[1][2] = AW'(w_p[0][2] * w_p[1][0]) - AW'(w_p[0][0] * w_p[1][2]);
        w_adj[2][0] = AW'(w_p[1][0] * w_p[2][1]) - AW'(w_p[1][1] * w_p[2][0]);
        w_adj[2][1] = AW'(w_p[0][1] * w_p[2][0]) - AW'(w_p[0][0] * w_p[2][1]);
        w_adj[2][2] = AW'(w_p[0][0] * w_p[1][1]) - AW'(w_p[0][1] * w_p[1][0]);
    end

    always_comb begin
        n_det = '0;
        for (int j = 0; j < 3; j++) begin
            n_det = n_det + DETW'(r_p0[j] * r_adj[j][0]);
        end
        n_dabs = r_det[DETW-1] ? DETW'(-r_det) : DETW'(r_det);
    end

    always_ff @(posedge i_clk) begin
        r_p0  <= w_p[0];
        r_adj <= w_adj;
        r_a   <= w_a;

        r_det    <= n_det;
        r_adjb   <= r_adj;
        r_a0     <= r_a[0];
        r_a_zero <= (r_a[0] == '0) || (r_a[1] == '0) || (r_a[2] == '0);
        for (int j = 0; j < 3; j++) begin
            r_oth[j] <= r_a[(j + 1) % 3] * r_a[(j + 2) % 3];
        end

        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                r_c[k][j] <= CW'(r_adjb[k][j] * $signed({1'b0, r_oth[j]}));
            end
        end
        r_a3   <= A3W'(r_oth[0] * r_a0);
        r_dmag <= n_dabs[DMAGW-1:0];
        r_dneg <= r_det[DETW-1];
        r_sing <= (r_det == '0) || r_a_zero;

        r_pl    <= r_a3 * r_dmag[23:0];
        r_ph    <= r_a3 * r_dmag[47:24];
        r_c2    <= r_c;
        r_dneg2 <= r_dneg;
        r_sing2 <= r_sing;

        o_coef.c        <= r_c2;
        o_coef.den2     <= D2W'(({r_ph, 24'd0} + {24'd0, r_pl}) << 1);
        o_coef.det_neg  <= r_dneg2;
        o_coef.singular <= r_sing2;
    end

endmodule

### sv/imc_lane.sv
// One output lane: weighted sum of the corrected triple, then a bit-per-stage
// rounded divide and saturation. Depends on imc_pkg.
module imc_lane (
    input  logic                                i_clk,
    input  logic [imc_pkg::LANE_ST-1:0]         i_en,
    input  logic [2:0][imc_pkg::VW-1:0]         i_v,
    input  logic [2:0][imc_pkg::CW-1:0]         i_c,
    input  logic [imc_pkg::D2W-1:0]             i_den2,
    input  logic                                i_det_neg,
    output logic [imc_pkg::MEAS_W-1:0]          o_res
);
    import imc_pkg::*;

    localparam int DIV0 = 4;
    localparam logic [QW-1:0] POS_LIM = QW'((64'd1 << (MEAS_W - 1)) - 64'd1);
    localparam logic [QW-1:0] NEG_LIM = QW'(64'd1 << (MEAS_W - 1));

    logic signed [67:0] r_phi [3];
    logic signed [66:0] r_plo [3];
    logic signed [NW-1:0] r_num;
    logic [RW-1:0] r_n2;
    logic          r_neg;

    logic [RW-1:0] r_rem [0:QW];
    logic [QW-1:0] r_q   [0:QW];
    logic          r_sneg [0:QW];
    logic          r_sovf [0:QW];

    logic signed [NW-1:0] n_num;
    logic [NW-1:0]        n_mag;
    logic [QW-1:0]        n_m, n_lim;
    logic [RW-1:0]        w_den;

    assign w_den = RW'(i_den2);

    always_comb begin
        n_num = '0;
        for (int j = 0; j < 3; j++) begin
            n_num = n_num + (NW'(r_phi[j]) <<< 32) + NW'(r_plo[j]);
        end
        n_mag = r_num[NW-1] ? NW'(-r_num) : NW'(r_num);
        n_lim = r_sneg[QW] ? NEG_LIM : POS_LIM;
        n_m   = (r_sovf[QW] || (r_q[QW] > n_lim)) ? n_lim : r_q[QW];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int j = 0; j < 3; j++) begin
                r_phi[j] <= $signed(i_v[j]) * $signed(i_c[j][CW-1:32]);
                r_plo[j] <= $signed(i_v[j]) * $signed({1'b0, i_c[j][31:0]});
            end
        end
        if (i_en[1]) begin
            r_num <= n_num;
        end
        if (i_en[2]) begin
            // half the divisor added for round to nearest
            r_n2  <= (RW'(n_mag) << 31) + (w_den >> 1);
            r_neg <= r_num[NW-1] ^ i_det_neg;
        end
        if (i_en[3]) begin
            r_rem[0]  <= r_n2;
            r_q[0]    <= '0;
            r_sneg[0] <= r_neg;
            r_sovf[0] <= r_n2 >= (w_den << QW);
        end
        for (int i = 0; i < QW; i++) begin
            if (i_en[DIV0 + i]) begin
                if (r_rem[i] >= (w_den << (QW - 1 - i))) begin
                    r_rem[i+1] <= r_rem[i] - (w_den << (QW - 1 - i));
                    r_q[i+1]   <= {r_q[i][QW-2:0], 1'b1};
                end else begin
                    r_rem[i+1] <= r_rem[i];
                    r_q[i+1]   <= {r_q[i][QW-2:0], 1'b0};
                end
                r_sneg[i+1] <= r_sneg[i];
                r_sovf[i+1] <= r_sovf[i];
            end
        end
        if (i_en[LANE_ST-1]) begin
            o_res <= r_sneg[QW] ? MEAS_W'(QW'(0) - n_m) : MEAS_W'(n_m);
        end
    end

endmodule

### sv/imu_measurement_compensation.sv
// Top level: register file, bias removal stage, six compensation lanes and the
// merging output stage. Depends on imc_pkg, imc_coef and imc_lane.
//
//  channel  signals                              direction
//  in       i_in_valid  o_in_ready  i_in         item in (t_in_item)
//  out      o_out_valid i_out_ready o_out        item out (t_out_item)
//  cfg      i_cfg_valid o_cfg_ready i_cfg_index  register write, i_cfg_data
//
// One item per cycle while o_in_ready is high; each lane has a 33-stage divider.
// Stages advance independently, so bubbles close up while the output stalls.
// After reset and after every register write, o_in_ready stays low
// while the coefficient pipelines settle. Reset is synchronous, active low.
module imu_measurement_compensation (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  imc_pkg::t_in_item                i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output imc_pkg::t_out_item               o_out,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [imc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [imc_pkg::CFG_W-1:0]        i_cfg_data
);
    import imc_pkg::*;

    localparam logic [DT_W+16:0] HALF = (DT_W + 17)'(1) << (DT_W - 1);

    logic [CFG_W-1:0]    r_cfg [CFG_NUM];
    logic [SETTLE_W-1:0] r_busy;
    logic [NS-1:0]       r_vld;
    logic [NS-1:0]       w_en;
    logic                w_in_acc;
    logic [5:0][VW-1:0]  r_v;
    logic [5:0][VW-1:0]  n_v;
    t_coef               w_coef [2];
    logic [MEAS_W-1:0]   w_res [6];
    logic signed [MEAS_W-1:0] w_meas [6];

    logic signed [16:0]    b;
    logic [16:0]           bmag;
    logic [DT_W+16:0]      prod;
    logic [17:0]           rr;
    logic signed [VW-1:0]  bd;

    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_in_ready  = w_en[0] && (r_busy == '0);
    assign o_out_valid = r_vld[NS-1];

    always_comb begin
        for (int s = 0; s < NS; s++) begin
            w_en[s] = i_out_ready | ~&(r_vld | ~({NS{1'b1}} << s));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_NUM; i++) begin
                r_cfg[i] <= '0;
            end
            r_busy <= SETTLE_W'(SETTLE);
            r_vld  <= '0;
        end else begin
            if (i_cfg_valid && (i_cfg_index < CFG_IDX_W'(CFG_NUM))) begin
                r_cfg[i_cfg_index[2:0]] <= i_cfg_data;
            end
            if (i_cfg_valid) begin
                r_busy <= SETTLE_W'(SETTLE);
            end else if (r_busy != '0) begin
                r_busy <= r_busy - 1'b1;
            end
            if (w_en[0]) begin
                r_vld[0] <= w_in_acc;
            end
            for (int s = 1; s < NS; s++) begin
                if (w_en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    // bias removal: v = meas - round(bias * dt)
    always_comb begin
        w_meas[0] = i_in.dvel_x;
        w_meas[1] = i_in.dvel_y;
        w_meas[2] = i_in.dvel_z;
        w_meas[3] = i_in.dang_x;
        w_meas[4] = i_in.dang_y;
        w_meas[5] = i_in.dang_z;
        b = '0; bmag = '0; prod = '0; rr = '0; bd = '0;
        for (int l = 0; l < 6; l++) begin
            b    = 17'($signed(r_cfg[(l / 3) * REGS_PER_SENSOR][(l % 3) * 16 +: 16]));
            bmag = b[16] ? 17'(-b) : 17'(b);
            prod = bmag * i_in.interval;
            rr   = 18'((prod + HALF) >> DT_W);
            bd   = b[16] ? -VW'(rr) : VW'(rr);
            n_v[l] = VW'(w_meas[l]) - bd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_v <= n_v;
        end
    end

    for (genvar s = 0; s < 2; s++) begin : g_coef
        imc_coef u_coef (
            .i_clk   (i_clk),
            .i_scale (r_cfg[s * REGS_PER_SENSOR + 1]),
            .i_mis_up(r_cfg[s * REGS_PER_SENSOR + 2]),
            .i_mis_lo(r_cfg[s * REGS_PER_SENSOR + 3]),
            .o_coef  (w_coef[s])
        );
    end

    for (genvar l = 0; l < 6; l++) begin : g_lane
        imc_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (w_en[LANE_ST:1]),
            .i_v      (r_v[(l / 3) * 3 +: 3]),
            .i_c      (w_coef[l / 3].c[l % 3]),
            .i_den2   (w_coef[l / 3].den2),
            .i_det_neg(w_coef[l / 3].det_neg),
            .o_res    (w_res[l])
        );
    end

    // merge lanes, zero a singular sensor
    always_ff @(posedge i_clk) begin
        if (w_en[NS-1]) begin
            o_out.comp_dvel_x    <= w_coef[0].singular ? '0 : w_res[0];
            o_out.comp_dvel_y    <= w_coef[0].singular ? '0 : w_res[1];
            o_out.comp_dvel_z    <= w_coef[0].singular ? '0 : w_res[2];
            o_out.comp_dang_x    <= w_coef[1].singular ? '0 : w_res[3];
            o_out.comp_dang_y    <= w_coef[1].singular ? '0 : w_res[4];
            o_out.comp_dang_z    <= w_coef[1].singular ? '0 : w_res[5];
            o_out.accel_singular <= w_coef[0].singular;
            o_out.gyro_singular  <= w_coef[1].singular;
        end
    end

endmodule

### test/tb.sv
// Testbench for imu_measurement_compensation: random and directed items checked against
// an exact-integer compensation predictor across several register settings.
// Depends on imc_pkg and the imu_measurement_compensation RTL.
`timescale 1ns / 1ps

module tb;
    import imc_pkg::*;

    localparam int WDOG_LIMIT = 20000;
    localparam int DRAIN      = 60;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 in_valid;
    logic                 in_ready;
    t_in_item             in_item;
    logic                 out_valid;
    logic                 out_ready;
    t_out_item            out_item;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    imu_measurement_compensation u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    logic [CFG_W-1:0] coef_regs [CFG_NUM];
    t_in_item         pending_items [$];
    t_out_item        expected_comp [$];
    int               errors;
    int               items_sent;
    int               items_checked;
    int               singular_seen;
    bit               no_idle;
    bit               hold_req;
    int               wdog;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // one sensor: remove integrated bias, apply inverse of (I + diag(scale)) * P
    function automatic void comp_sensor(input logic [2:0][31:0] meas,
                                        input logic [3:0][CFG_W-1:0] rg,
                                        input longint dt,
                                        output logic [2:0][31:0] res,
                                        output logic sing);
        longint a [3];
        longint p [3][3];
        longint adj [3][3];
        longint v [3];
        longint det, b, rr, dmag, lim32;
        logic signed [191:0] num, den, t, q, lim;
        bit neg;
        lim32 = 64'sd1 <<< 32;
        for (int i = 0; i < 3; i++) begin
            a[i] = 32768 + longint'($signed(rg[1][16*i +: 16]));
            p[i][i] = 32768;
        end
        p[0][1] = longint'($signed(rg[2][15:0]));
        p[0][2] = longint'($signed(rg[2][31:16]));
        p[1][0] = longint'($signed(rg[2][47:32]));
        p[1][2] = longint'($signed(rg[3][15:0]));
        p[2][0] = longint'($signed(rg[3][31:16]));
        p[2][1] = longint'($signed(rg[3][47:32]));
        adj[0][0] = p[1][1]*p[2][2] - p[1][2]*p[2][1];
        adj[0][1] = p[0][2]*p[2][1] - p[0][1]*p[2][2];
        adj[0][2] = p[0][1]*p[1][2] - p[0][2]*p[1][1];
        adj[1][0] = p[1][2]*p[2][0] - p[1][0]*p[2][2];
        adj[1][1] = p[0][0]*p[2][2] - p[0][2]*p[2][0];
        adj[1][2] = p[0][2]*p[1][0] - p[0][0]*p[1][2];
        adj[2][0] = p[1][0]*p[2][1] - p[1][1]*p[2][0];
        adj[2][1] = p[0][1]*p[2][0] - p[0][0]*p[2][1];
        adj[2][2] = p[0][0]*p[1][1] - p[0][1]*p[1][0];
        det = p[0][0]*adj[0][0] + p[0][1]*adj[1][0] + p[0][2]*adj[2][0];
        res = '0;
        sing = 1'b1;
        if (det == 0 || a[0] == 0 || a[1] == 0 || a[2] == 0) return;
        sing = 1'b0;
        for (int j = 0; j < 3; j++) begin
            b  = longint'($signed(rg[0][16*j +: 16]));
            rr = ((b < 0 ? -b : b) * dt + (64'sd1 <<< (DT_W-1))) >>> DT_W;
            v[j] = longint'($signed(meas[j])) - (b < 0 ? -rr : rr);
            if (v[j] > lim32) v[j] = lim32;
            if (v[j] < -lim32) v[j] = -lim32;
        end
        dmag = det < 0 ? -det : det;
        den = a[0] * a[1] * a[2];
        den = den * dmag;
        for (int k = 0; k < 3; k++) begin
            num = 0;
            for (int j = 0; j < 3; j++) begin
                t = adj[k][j];
                t = t * v[j];
                t = t * (a[(j+1)%3] * a[(j+2)%3]);
                num = num + (t <<< 30);
            end
            neg = num < 0;
            if (neg) num = -num;
            q = (2*num + den) / (2*den);
            neg = neg ^ (det < 0);
            lim = neg ? (192'sd1 <<< 31) : (192'sd1 <<< 31) - 1;
            if (q > lim) q = lim;
            if (neg) q = -q;
            res[k] = q[31:0];
        end
    endfunction

    function automatic t_out_item predict_comp(input t_in_item it);
        t_out_item          r;
        logic [2:0][31:0]   ra, rgy;
        logic               sa, sg;
        comp_sensor({it.dvel_z, it.dvel_y, it.dvel_x},
                    {coef_regs[3], coef_regs[2], coef_regs[1], coef_regs[0]},
                    longint'(it.interval), ra, sa);
        comp_sensor({it.dang_z, it.dang_y, it.dang_x},
                    {coef_regs[7], coef_regs[6], coef_regs[5], coef_regs[4]},
                    longint'(it.interval), rgy, sg);
        r.comp_dvel_x = ra[0];  r.comp_dvel_y = ra[1];  r.comp_dvel_z = ra[2];
        r.comp_dang_x = rgy[0]; r.comp_dang_y = rgy[1]; r.comp_dang_z = rgy[2];
        r.accel_singular = sa;
        r.gyro_singular  = sg;
        return r;
    endfunction

    task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("%0t: %s got %h want %h", $realtime, field, got, want);
    endtask

    // driver
    int gap_cnt;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_cnt  <= 0;
        end else begin
            if (in_valid && in_ready) begin
                expected_comp.push_back(predict_comp(in_item));
                items_sent++;
            end
            if (!in_valid || in_ready) begin
                if (gap_cnt > 0) begin
                    gap_cnt  <= gap_cnt - 1;
                    in_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    if (!no_idle && $urandom_range(0, 9) == 0) begin
                        gap_cnt  <= $urandom_range(0, 14);
                        in_valid <= 1'b0;
                    end else begin
                        in_item  <= pending_items.pop_front();
                        in_valid <= 1'b1;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    int  stall_cnt;
    int  hold_cnt;
    bit  hold_done;
    always @(posedge i_clk) begin
        t_out_item w;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            stall_cnt <= 0;
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_comp.size() == 0) begin
                    errors++;
                    $display("%0t: result with nothing expected", $realtime);
                end else begin
                    w = expected_comp.pop_front();
                    items_checked++;
                    if (w.accel_singular || w.gyro_singular) singular_seen++;
                    if (out_item.comp_dvel_x !== w.comp_dvel_x)
                        report("comp_dvel_x", out_item.comp_dvel_x, w.comp_dvel_x);
                    if (out_item.comp_dvel_y !== w.comp_dvel_y)
                        report("comp_dvel_y", out_item.comp_dvel_y, w.comp_dvel_y);
                    if (out_item.comp_dvel_z !== w.comp_dvel_z)
                        report("comp_dvel_z", out_item.comp_dvel_z, w.comp_dvel_z);
                    if (out_item.comp_dang_x !== w.comp_dang_x)
                        report("comp_dang_x", out_item.comp_dang_x, w.comp_dang_x);
                    if (out_item.comp_dang_y !== w.comp_dang_y)
                        report("comp_dang_y", out_item.comp_dang_y, w.comp_dang_y);
                    if (out_item.comp_dang_z !== w.comp_dang_z)
                        report("comp_dang_z", out_item.comp_dang_z, w.comp_dang_z);
                    if (out_item.accel_singular !== w.accel_singular)
                        report("accel_singular", 32'(out_item.accel_singular),
                               32'(w.accel_singular));
                    if (out_item.gyro_singular !== w.gyro_singular)
                        report("gyro_singular", 32'(out_item.gyro_singular),
                               32'(w.gyro_singular));
                end
            end
            if (hold_req && !hold_done) begin
                hold_done <= 1'b1;
                hold_cnt  <= 300;
                out_ready <= 1'b0;
            end else if (hold_cnt > 0) begin
                hold_cnt  <= hold_cnt - 1;
                out_ready <= 1'b0;
            end else if (stall_cnt > 0) begin
                stall_cnt <= stall_cnt - 1;
                out_ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 9) == 0) begin
                stall_cnt <= $urandom_range(0, 14);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any accepted item or write
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready)) begin
            wdog <= 0;
        end else if (wdog >= WDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            wdog <= wdog + 1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!(cfg_valid && cfg_ready));
        if (idx < CFG_NUM) coef_regs[idx[2:0]] = data;
        cfg_valid <= 1'b0;
    endtask

    // checked between edges so the driver's updates have settled
    task automatic wait_idle();
        while (pending_items.size() > 0 || in_valid || expected_comp.size() > 0)
            @(negedge i_clk);
        repeat (NS + 5) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_meas();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 2000) - 1000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        it.dvel_x = rand_meas(); it.dvel_y = rand_meas(); it.dvel_z = rand_meas();
        it.dang_x = rand_meas(); it.dang_y = rand_meas(); it.dang_z = rand_meas();
        case ($urandom_range(0, 5))
            0: it.interval = '1;
            1: it.interval = '0;
            default: it.interval = DT_W'($urandom);
        endcase
        return it;
    endfunction

    function automatic logic [15:0] small_coef();
        return 16'($urandom_range(0, 4095)) - 16'd2048;
    endfunction

    initial begin
        t_in_item          it;
        logic [CFG_W-1:0]  d;
        logic [31:0]       ext [4];
        errors = 0; items_sent = 0; items_checked = 0; singular_seen = 0;
        no_idle = 1'b0; hold_req = 1'b0;
        in_valid = 1'b0; in_item = '0; out_ready = 1'b0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        foreach (coef_regs[i]) coef_regs[i] = '0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset coefficients, extreme measurements and intervals
        ext = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0};
        for (int i = 0; i < 4; i++) begin
            it = '{ext[i], ext[i], ext[i], ext[(i+1)%4], ext[(i+2)%4], ext[(i+3)%4],
                   (i % 2) ? 24'hFF_FFFF : 24'h0};
            pending_items.push_back(it);
        end
        wait_idle();

        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: begin // largest positive coefficients: large bias, near singular
                    for (int r = 0; r < CFG_NUM; r++)
                        write_reg(CFG_IDX_W'(r), {3{16'h7FFF}});
                end
                1: begin // most negative: scale of -1 makes both sensors singular
                    for (int r = 0; r < CFG_NUM; r++)
                        write_reg(CFG_IDX_W'(r), {3{16'h8000}});
                end
                2: begin // gyro misalignment near singular, accel clean
                    write_reg(REG_ACC_BIAS, {16'h8000, 16'h7FFF, 16'h0001});
                    write_reg(REG_ACC_SCL, '0);
                    write_reg(REG_ACC_MUP, '0);
                    write_reg(REG_ACC_MLO, '0);
                    write_reg(REG_GYR_BIAS, '1);
                    write_reg(REG_GYR_SCL, '0);
                    write_reg(REG_GYR_MUP, {16'h7FFF, 16'h0, 16'h7FFF});
                    write_reg(REG_GYR_MLO, '0);
                    write_reg(8'd9, '1);
                    write_reg(8'hFF, '1);
                end
                default: begin
                    for (int r = 0; r < CFG_NUM; r++) begin
                        if (ph % 3 == 0)
                            d = CFG_W'({$urandom, $urandom});
                        else if (r % REGS_PER_SENSOR == 0)
                            d = {16'($urandom), 16'($urandom), 16'($urandom)};
                        else
                            d = {small_coef(), small_coef(), small_coef()};
                        write_reg(CFG_IDX_W'(r), d);
                    end
                end
            endcase
            if (ph == 4) hold_req = 1'b1;
            if (ph == 9) no_idle = 1'b1;
            for (int n = 0; n < (ph < 3 ? 40 : 150); n++)
                pending_items.push_back(rand_item());
            wait_idle();
        end

        repeat (DRAIN) @(posedge i_clk);
        $display("Checked %0d of %0d items over 11 coefficient settings, %0d with a singular flag.",
                 items_checked, items_sent, singular_seen);
        if (errors == 0 && expected_comp.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, expected_comp.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

### files.f
sv/imc_pkg.sv
sv/imc_coef.sv
sv/imc_lane.sv
sv/imu_measurement_compensation.sv
test/tb.sv
